// ===== design/fpc_pkg.sv =====
// fpc_pkg: shared types and constants for the filtered pearson correlation block
// no dependencies

package fpc_pkg;

  localparam int MaxSamples = 4096;
  localparam int CntW       = $clog2(MaxSamples + 1);
  localparam int SampleW    = 16;
  localparam int SumW       = 29;
  localparam int SqW        = 43;
  localparam int PrW        = 44;
  localparam int WideW      = 64;
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);

  localparam logic [1:0] RegLow  = 2'd0;
  localparam logic [1:0] RegHigh = 2'd1;
  localparam logic [1:0] RegMin  = 2'd2;

  // classified item passed from front to back
  typedef struct packed {
    logic                      ok;
    logic                      last;
    logic signed [SampleW-1:0] x;
    logic signed [SampleW-1:0] y;
  } item_t;

  typedef enum logic [3:0] {
    S_ACC, S_PROD, S_PREP, S_DEN, S_RHS, S_SRCH, S_SMUL, S_SCMP, S_OUT
  } back_state_t;

endpackage

// ===== design/filtered_pearson_correlation.sv =====
// filtered pearson correlation: one sample pair per cycle into the sums while the
// back end accumulates; each pair passes through the 4-entry front queue before the back end takes it;
// after the last pair the back end forms the products, a prepare step, the shift-add
// multiplies dx*dy and mag*mag, the binary search steps and the output load;
// an invalid result goes from prepare to output; input stalls while the queue is full
// rst is synchronous and clears sums, queue and registers to their reset values
module filtered_pearson_correlation (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] x_sample,
  input  logic               x_missing,
  input  logic signed [15:0] y_sample,
  input  logic               y_missing,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] correlation,
  output logic               correlation_valid,
  output logic [12:0]        pairs_used
);
  import fpc_pkg::*;

  logic signed [15:0] low_bound, high_bound;
  logic [CntW-1:0]    min_valid_pairs;
  logic               q_valid, q_take;
  item_t              q_item;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bound <= 16'sd0;
      high_bound <= 16'sd20480;
      min_valid_pairs <= CntW'(30);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegLow:  low_bound <= pwdata[15:0];
        RegHigh: high_bound <= pwdata[15:0];
        RegMin:  min_valid_pairs <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegLow:  prdata = 32'($signed(low_bound));
      RegHigh: prdata = 32'($signed(high_bound));
      RegMin:  prdata = 32'(min_valid_pairs);
      default: prdata = '0;
    endcase
  end

  fpc_front u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .x_sample, .x_missing,
    .y_sample, .y_missing, .last_sample, .low_bound, .high_bound,
    .q_valid, .q_item, .q_take
  );

  fpc_back u_back (
    .clk, .rst, .q_valid, .q_item, .q_take, .min_valid_pairs,
    .valid(out_valid), .stall(out_stall), .correlation, .correlation_valid, .pairs_used
  );

endmodule

// ===== design/fpc_front.sv =====
// fpc_front: input acceptance, pair filtering and the small queue to the back end
// depends on fpc_pkg

module fpc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid,
  output logic                            stall,
  input  logic signed [fpc_pkg::SampleW-1:0] x_sample,
  input  logic                            x_missing,
  input  logic signed [fpc_pkg::SampleW-1:0] y_sample,
  input  logic                            y_missing,
  input  logic                            last_sample,
  input  logic signed [fpc_pkg::SampleW-1:0] low_bound,
  input  logic signed [fpc_pkg::SampleW-1:0] high_bound,
  output logic                            q_valid,
  output fpc_pkg::item_t                  q_item,
  input  logic                            q_take
);
  import fpc_pkg::*;

  item_t            mem [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW:0]   fill;
  logic             push;
  item_t            in_item;

  assign stall = (fill == QPtrW'(0) + (QPtrW+1)'(QDepth));
  assign push  = valid && !stall;

  always_comb begin
    in_item.ok   = !x_missing && !y_missing && (low_bound < x_sample) &&
                   (x_sample < high_bound) && (low_bound < y_sample) &&
                   (y_sample < high_bound);
    in_item.last = last_sample;
    in_item.x    = x_sample;
    in_item.y    = y_sample;
  end

  assign q_valid = (fill != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_take) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QPtrW+1)'(push) - (QPtrW+1)'(q_take);
    end
  end

endmodule

// ===== design/fpc_back.sv =====
// fpc_back: accumulation of sums and the per-vector coefficient sequencer
// depends on fpc_pkg

module fpc_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  fpc_pkg::item_t           q_item,
  output logic                     q_take,
  input  logic [fpc_pkg::CntW-1:0] min_valid_pairs,
  output logic                     valid,
  input  logic                     stall,
  output logic signed [15:0]       correlation,
  output logic                     correlation_valid,
  output logic [fpc_pkg::CntW-1:0] pairs_used
);
  import fpc_pkg::*;

  back_state_t state, state_next;

  logic [CntW-1:0]              n;
  logic signed [SumW-1:0]       sx, sy;
  logic [SqW-1:0]               sxx, syy;
  logic signed [PrW-1:0]        sxy;
  logic signed [31:0]           pxx, pyy, pxy;
  logic                         add_pair;

  logic [3:0]                   step;
  logic signed [CntW:0]         op_n;
  logic signed [SqW+1:0]        op_s;
  logic signed [SumW-1:0]       op_a, op_b;
  logic signed [CntW+SqW+2:0]   prod_ns;
  logic signed [2*SumW-1:0]     prod_ab;
  logic [WideW-1:0]             diff;
  logic [WideW-1:0]             num, dx, dy, mag;
  logic                         neg, ok_v, ok_now;
  logic [3:0]                   nib;
  logic [WideW-1:0]             nopnd;
  logic [WideW+3:0]             npart;
  logic [7:0]                   mbyte;
  logic [135:0]                 mpart;
  logic [127:0]                 den, rhs;
  logic [16:0]                  lo, hi, mid;
  logic [31:0]                  msq;
  logic [159:0]                 lhs;
  logic                         load_out;

  // per-pair products for the sums
  always_comb begin
    pxx      = q_item.x * q_item.x;
    pyy      = q_item.y * q_item.y;
    pxy      = q_item.x * q_item.y;
    add_pair = q_take && q_item.ok && (n < CntW'(MaxSamples));
  end

  // n*S - Sa*Sb, one of num, dx, dy per cycle
  always_comb begin
    op_n = $signed({1'b0, n});
    case (step[1:0])
      2'd0: begin
        op_s = (SqW+2)'(sxy);
        op_a = sx;
        op_b = sy;
      end
      2'd1: begin
        op_s = $signed({2'b00, sxx});
        op_a = sx;
        op_b = sx;
      end
      default: begin
        op_s = $signed({2'b00, syy});
        op_a = sy;
        op_b = sy;
      end
    endcase
    prod_ns = op_n * op_s;
    prod_ab = op_a * op_b;
    diff    = WideW'(prod_ns) - WideW'(prod_ab);
  end

  // narrow slices for the shift-add multiplies
  always_comb begin
    nib   = (state == S_DEN) ? dy[4*step +: 4] : mag[4*step +: 4];
    nopnd = (state == S_DEN) ? dx : mag;
    npart = nopnd * nib;
    mbyte = msq[8*step[1:0] +: 8];
    mpart = den * mbyte;
  end

  assign mid    = (lo + hi + 17'd1) >> 1;
  assign ok_now = (n >= min_valid_pairs) && (dx != '0) && (dy != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_ACC:  if (q_take && q_item.last) state_next = S_PROD;
      S_PROD: if (step == 4'd2) state_next = S_PREP;
      S_PREP: state_next = ok_now ? S_DEN : S_OUT;
      S_DEN:  if (step == 4'd15) state_next = S_RHS;
      S_RHS:  if (step == 4'd15) state_next = S_SRCH;
      S_SRCH: state_next = (lo < hi) ? S_SMUL : S_OUT;
      S_SMUL: if (step == 4'd3) state_next = S_SCMP;
      S_SCMP: state_next = S_SRCH;
      S_OUT:  if (load_out) state_next = S_ACC;
      default: state_next = S_ACC;
    endcase
  end

  // outputs
  always_comb begin
    q_take   = (state == S_ACC) && q_valid;
    load_out = (state == S_OUT) && (!valid || !stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_out) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      n <= '0; sx <= '0; sy <= '0; sxx <= '0; syy <= '0; sxy <= '0;
      step <= '0;
      correlation       <= '0;
      correlation_valid <= 1'b0;
      pairs_used        <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_ACC: begin
          step <= '0;
          if (add_pair) begin
            n   <= n + CntW'(1);
            sx  <= sx + SumW'(q_item.x);
            sy  <= sy + SumW'(q_item.y);
            sxx <= sxx + SqW'($unsigned(pxx));
            syy <= syy + SqW'($unsigned(pyy));
            sxy <= sxy + PrW'(pxy);
          end
        end
        S_PROD: begin
          step <= step + 4'd1;
          case (step[1:0])
            2'd0:    num <= diff;
            2'd1:    dx  <= diff;
            default: dy  <= diff;
          endcase
        end
        S_PREP: begin
          neg  <= num[WideW-1];
          mag  <= num[WideW-1] ? -num : num;
          ok_v <= ok_now;
          den  <= '0;
          rhs  <= '0;
          step <= '0;
          lo   <= '0;
          hi   <= 17'd32768;
        end
        S_DEN: begin
          // den = dx*dy, 4 bits of dy per cycle
          den  <= den + (128'(npart) << (4*step));
          step <= step + 4'd1;
        end
        S_RHS: begin
          // mag*mag, 4 bits per cycle; the 2^30 scale is applied at the compare
          rhs  <= rhs + (128'(npart) << (4*step));
          step <= step + 4'd1;
        end
        S_SRCH: begin
          msq  <= 32'(mid) * 32'(mid);
          lhs  <= '0;
          step <= '0;
        end
        S_SMUL: begin
          lhs  <= lhs + (160'(mpart) << (8*step[1:0]));
          step <= step + 4'd1;
        end
        S_SCMP: begin
          if (lhs <= (160'(rhs) << 30)) lo <= mid;
          else hi <= mid - 17'd1;
        end
        S_OUT: begin
          if (load_out) begin
            correlation_valid <= ok_v;
            pairs_used        <= n;
            if (!ok_v) correlation <= '0;
            else if (neg) correlation <= 16'(17'h10000 - lo);
            else correlation <= (lo > 17'd32767) ? 16'sd32767 : 16'(lo);
            n <= '0; sx <= '0; sy <= '0; sxx <= '0; syy <= '0; sxy <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/fpc_checker.sv =====
// fpc_checker: port-level assertions for filtered_pearson_correlation
// depends on fpc_pkg; bound to the top level below

module fpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] correlation,
  input logic        correlation_valid,
  input logic        pready
);
  import fpc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(correlation))
    else $error("stalled result changed");

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !correlation_valid |-> correlation == 16'd0)
    else $error("invalid result not zero");

  a_rdy: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind filtered_pearson_correlation fpc_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .correlation, .correlation_valid, .pready
);

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for filtered_pearson_correlation
// depends on fpc_pkg and the filtered_pearson_correlation rtl; predicts each
// coefficient with exact wide integer arithmetic and checks every result transaction

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fpc_pkg::*;

  localparam int  Limit    = 3000000;
  localparam int  Drain    = 900;
  localparam int  HoldOff  = 3000;
  localparam logic [3:0] AddrBad = 4'd12;

  typedef struct {
    logic signed [15:0] corr;
    logic               cvalid;
    logic [12:0]        pairs;
  } coeff_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] x_sample = '0, y_sample = '0;
  logic x_missing = 1'b0, y_missing = 1'b0, last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] correlation;
  logic correlation_valid;
  logic [12:0] pairs_used;

  filtered_pearson_correlation DUT (.*);

  always #6 clk = ~clk;

  // predictor state
  int    lo_b = 0, hi_b = 20480, min_pairs = 30;
  longint acc_n, acc_sx, acc_sy, acc_sxx, acc_syy, acc_sxy;
  coeff_t expected_coeffs[$];
  int    errors = 0;
  bit    quiet = 1'b0;
  bit    hold_req = 1'b0;
  int    hold_cnt = 0;
  int    cycles = 0;

  function automatic coeff_t coefficient();
    coeff_t r;
    longint num, dx, dy, mag;
    logic [255:0] den, rhs, lhs;
    longint lo, hi, mid;
    num = acc_n * acc_sxy - acc_sx * acc_sy;
    dx  = acc_n * acc_sxx - acc_sx * acc_sx;
    dy  = acc_n * acc_syy - acc_sy * acc_sy;
    mag = (num < 0) ? -num : num;
    r.cvalid = (acc_n >= min_pairs) && (dx != 0) && (dy != 0);
    r.pairs  = acc_n[12:0];
    r.corr   = '0;
    if (r.cvalid) begin
      den = 256'(dx) * 256'(dy);
      rhs = (256'(mag) * 256'(mag)) << 30;
      lo = 0;
      hi = 32768;
      // largest m with m^2 * den <= num^2 * 2^30
      while (lo < hi) begin
        mid = (lo + hi + 1) >>> 1;
        lhs = 256'(mid * mid) * den;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (num < 0) r.corr = 16'((32'h10000 - lo) & 32'hffff);
      else r.corr = (lo > 32767) ? 16'sd32767 : 16'(lo);
    end
    return r;
  endfunction

  function automatic void accumulate(int x, bit xm, int y, bit ym, bit last);
    bit ok;
    ok = !xm && !ym && lo_b < x && x < hi_b && lo_b < y && y < hi_b;
    if (ok && acc_n < MaxSamples) begin
      acc_sx += x;
      acc_sy += y;
      acc_sxx += longint'(x) * x;
      acc_syy += longint'(y) * y;
      acc_sxy += longint'(x) * y;
      acc_n++;
    end
    if (last) begin
      expected_coeffs.insert(expected_coeffs.size(), coefficient());
      acc_n = 0; acc_sx = 0; acc_sy = 0; acc_sxx = 0; acc_syy = 0; acc_sxy = 0;
    end
  endfunction

  // entered and left at a falling edge
  task automatic send_pair(input int x, input bit xm, input int y, input bit ym,
                           input bit last);
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    x_sample = 16'(x);
    x_missing = xm;
    y_sample = 16'(y);
    y_missing = ym;
    last_sample = last;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    accumulate(int'(x_sample), xm, int'(y_sample), ym, last);
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_valid = 1'b0;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [3:0] addr,
                           input logic [31:0] val);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == {idx, 2'b00}) begin
      case (idx)
        RegLow:  lo_b = int'($signed(val[15:0]));
        RegHigh: hi_b = int'($signed(val[15:0]));
        RegMin:  min_pairs = int'(val[12:0]);
        default: ;
      endcase
    end
  endtask

  // all results in and the back end idle before touching registers
  task automatic wait_idle();
    idle_input();
    wait (expected_coeffs.size() == 0);
    repeat (Drain) @(negedge clk);
  endtask

  task automatic configure(input int lo, input int hi, input int mn);
    wait_idle();
    reg_write(RegLow, {RegLow, 2'b00}, 32'(lo));
    reg_write(RegHigh, {RegHigh, 2'b00}, 32'(hi));
    reg_write(RegMin, {RegMin, 2'b00}, 32'(mn));
  endtask

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      2: return clamp16(lo_b + 1);
      3: return clamp16(hi_b - 1);
      4, 5: return int'($signed(16'($urandom)));
      default: return (lo_b < hi_b - 1) ?
                      lo_b + 1 + int'($urandom_range(hi_b - lo_b - 2)) : 0;
    endcase
  endfunction

  task automatic send_vector(input int len);
    int x, y, mode;
    mode = $urandom_range(3);
    for (int i = 0; i < len; i++) begin
      x = pick_sample();
      case (mode)
        0: y = x;
        1: y = clamp16(-x);
        2: y = clamp16(x + int'($urandom_range(800)) - 400);
        default: y = pick_sample();
      endcase
      send_pair(x, $urandom_range(99) < 8, y, $urandom_range(99) < 8, i == len - 1);
    end
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = HoldOff;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      out_stall = 1'b1;
      hold_cnt--;
    end else begin
      out_stall = !quiet && ($urandom_range(99) < 17);
    end
  end

  always @(posedge clk) begin
    coeff_t e;
    cycles++;
    if (cycles > Limit) begin
      $display("filtered_pearson_correlation: mismatch");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_coeffs.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        e = expected_coeffs.pop_front();
        if (correlation !== e.corr) begin
          $error("correlation expected %0d got %0d", e.corr, correlation);
          errors++;
        end
        if (correlation_valid !== e.cvalid) begin
          $error("correlation_valid expected %0d got %0d", e.cvalid, correlation_valid);
          errors++;
        end
        if (pairs_used !== e.pairs) begin
          $error("pairs_used expected %0d got %0d", e.pairs, pairs_used);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_values();
    // exclusive bounds at the reset window, and enough pairs to pass the minimum
    send_pair(0, 0, 5, 0, 0);
    send_pair(20480, 0, 5, 0, 0);
    send_pair(20479, 0, 1, 0, 0);
    for (int i = 0; i < 32; i++) send_pair(100 * i + 1, 0, 90 * i + 7, 0, i == 31);
  endtask

  task automatic test_directed();
    configure(-32768, 32767, 0);
    send_pair(5, 0, 5, 0, 1);                       // one pair: zero denominator
    send_pair(-32768, 0, 32767, 0, 1);              // nothing valid
    send_pair(1000, 0, 1, 0, 0);
    send_pair(1000, 0, 2, 0, 0);
    send_pair(1000, 0, 3, 0, 1);                    // constant x
    send_pair(-32767, 0, -32767, 0, 0);
    send_pair(32766, 0, 32766, 0, 0);
    send_pair(12, 0, 12, 0, 1);                     // perfect positive
    send_pair(-32767, 0, 32766, 0, 0);
    send_pair(32766, 0, -32767, 0, 0);
    send_pair(40, 1, 9, 0, 0);                      // missing x
    send_pair(41, 0, 9, 1, 0);                      // missing y
    send_pair(7, 0, -7, 0, 1);                      // nearly perfect negative
    configure(-32768, 32767, 4096);
    for (int i = 0; i < 5; i++) send_pair(i * 300, 0, -i * 77, 0, i == 4);
    configure(100, 100, 1);                         // equal bounds, no pair passes
    send_pair(100, 0, 100, 0, 0);
    send_pair(50, 0, 150, 0, 1);
    wait_idle();
    reg_write(RegLow, AddrBad, 32'h1234);           // unknown register
    reg_write(RegLow, {RegLow, 2'b00}, 32'(-500));
    reg_write(RegHigh, {RegHigh, 2'b00}, 32'(500));
    for (int i = 0; i < 6; i++) send_pair(i * 90 - 250, 0, i * i * 20 - 400, 0, i == 5);
  endtask

  task automatic test_random();
    int cfg_lo[4] = '{-32768, -20000, 0, -1024};
    int cfg_hi[4] = '{32767, 30000, 20480, 1024};
    int cfg_mn[4] = '{0, 10, 30, 4096};
    int sent;
    int len;
    for (int p = 0; p < 4; p++) begin
      configure(cfg_lo[p], cfg_hi[p], cfg_mn[p]);
      quiet = (p == 0);
      sent = 0;
      while (sent < 475) begin
        if ($urandom_range(9) == 0) len = int'($urandom_range(1, 4));
        else len = int'($urandom_range(10, 60));
        send_vector(len);
        sent += len;
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    configure(-32768, 32767, 2);
    hold_req = 1'b1;
    for (int v = 0; v < 12; v++) send_vector(3);
  endtask

  initial begin
    acc_n = 0; acc_sx = 0; acc_sy = 0; acc_sxx = 0; acc_syy = 0; acc_sxy = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_reset_values();
    test_directed();
    test_random();
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("filtered_pearson_correlation: match");
    end else begin
      $display("filtered_pearson_correlation: mismatch");
    end
    $finish;
  end

endmodule
